// File: hw/rtl/smkt_pkg.sv
// ============================================================================
// smkt_pkg
// Shared constants, codes and types of the sorted multi-word key table.
// ============================================================================
package smkt_pkg;

    // Table geometry
    localparam int CAPACITY      = 256;
    localparam int MAX_KEY_WORDS = 4;
    localparam int WORD_W        = 32;
    localparam int ROW_W         = MAX_KEY_WORDS * WORD_W;
    localparam int ADDR_W        = $clog2(CAPACITY);
    localparam int CNT_W         = ADDR_W + 1;

    // Field widths
    localparam int IDX_W         = 10;
    localparam int WIK_W         = 3;
    localparam int WIK_RESET     = 2;
    localparam int OFS_W         = 2;
    localparam int BEGIN_W       = 9;
    localparam int END_W         = 10;

    // Stream payload widths
    localparam int S_TDATA_W     = 152;
    localparam int M_TDATA_W     = 32;

    // Index value that marks "no entry"
    localparam logic [IDX_W-1:0] IDX_NONE = '1;

    // Operation codes carried in s_tuser
    typedef enum logic [1:0] {
        MODE_BOUND  = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_INSERT = 2'd2,
        MODE_DELETE = 2'd3
    } mode_t;

    // Access request to the key store
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic              wr_from_rd;
        logic [ADDR_W-1:0] wr_addr;
    } mem_req_t;

    // Comparison of the last row read against the search key
    typedef struct packed {
        logic row_lt;
        logic row_eq;
    } cmp_res_t;

endpackage

// File: hw/rtl/smkt_key_store.sv
// ============================================================================
// smkt_key_store
// Key row memory with registered read data and a lexicographic comparator
// of the row read against the current search key.
// ============================================================================
module smkt_key_store
(
    input  logic                                 clk,
    input  smkt_pkg::mem_req_t                   req,
    input  logic [smkt_pkg::ROW_W-1:0]           key,
    input  logic [smkt_pkg::MAX_KEY_WORDS-1:0]   word_mask,
    output smkt_pkg::cmp_res_t                   cmp
);
    import smkt_pkg::*;

    logic [ROW_W-1:0] mem [CAPACITY];
    logic [ROW_W-1:0] rd_data_reg;
    logic [ROW_W-1:0] wr_data;

    // Select a moved row or the search key as write data
    assign wr_data = req.wr_from_rd ? rd_data_reg : key;

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= wr_data;
        end
    end

    // Synchronous read port
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    // Compare active words, word 0 decides first
    always_comb
    begin
        logic [WORD_W-1:0] row_w;
        logic [WORD_W-1:0] key_w;
        cmp.row_lt = 1'b0;
        cmp.row_eq = 1'b1;
        for (int w = MAX_KEY_WORDS - 1; w >= 0; w--)
        begin
            row_w = rd_data_reg[w*WORD_W +: WORD_W];
            key_w = key[w*WORD_W +: WORD_W];
            if (word_mask[w] && (row_w != key_w))
            begin
                cmp.row_lt = (row_w < key_w);
                cmp.row_eq = 1'b0;
            end
        end
    end

endmodule

// File: hw/rtl/sorted_multiword_key_table_unit.sv
// ============================================================================
// sorted_multiword_key_table_unit
// Sorted table of multi-word keys with bound search, lookup, insert, delete.
// ============================================================================
// One operation is in flight at a time; s_tready is high whenever the unit
// is idle, also while the previous result still waits on the master side.
// A binary search halves the range in two steps, one memory read and one
// compare. Lookup and delete then read and check the found row. Insert and
// delete then move every later row by one place at one row per cycle: each
// cycle reads one row while the row read just before it goes back through
// the memory's separate write port. Insert then drains and writes the key,
// delete only drains. No clearing pass runs after reset.
module sorted_multiword_key_table_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration: words_in_key
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [smkt_pkg::WIK_W-1:0]        cfg_data,
    // Operation stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] key_word_0, [63:32] key_word_1, [95:64] key_word_2,
    // [127:96] key_word_3, [129:128] search_offset, [138:130] range_begin,
    // [148:139] range_end, [151:149] zero
    input  logic [smkt_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] mode
    input  logic [1:0]                        s_tuser,
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [9:0] index, [18:10] insert_position, [27:19] entry_count, [31:28] zero
    output logic [smkt_pkg::M_TDATA_W-1:0]    m_tdata,
    // [0] found, [1] status
    output logic [1:0]                        m_tuser
);
    import smkt_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_SEARCH = 9'b000000010,
        ST_CMP    = 9'b000000100,
        ST_VREAD  = 9'b000001000,
        ST_VCMP   = 9'b000010000,
        ST_SHIFT  = 9'b000100000,
        ST_DRAIN  = 9'b001000000,
        ST_KEYWR  = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [WIK_W-1:0]       words_reg, words_next;
    logic                   mv_valid_reg, mv_valid_next;
    logic                   m_tvalid_reg, m_tvalid_next;

    logic [ADDR_W-1:0]      mv_addr_reg, mv_addr_next;
    logic [ADDR_W-1:0]      ptr_reg, ptr_next;
    logic [ADDR_W-1:0]      mid_reg, mid_next;
    logic [CNT_W-1:0]       lo_reg, lo_next;
    logic [CNT_W-1:0]       hi_reg, hi_next;
    mode_t                  mode_reg, mode_next;
    logic [ROW_W-1:0]       key_reg, key_next;
    logic [OFS_W-1:0]       ofs_reg, ofs_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   found_reg, found_next;
    logic                   status_reg, status_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [1:0]             m_tuser_reg, m_tuser_next;

    logic [MAX_KEY_WORDS-1:0] word_mask;
    logic [WIK_W-1:0]       words_eff;
    logic [CNT_W-1:0]       end_eff;
    logic [CNT_W-1:0]       begin_in;
    logic [IDX_W-1:0]       mid_sum;
    logic [CNT_W-1:0]       lo_plus1;
    logic                   out_free;
    mem_req_t               req;
    cmp_res_t               cmp;

    // Clamp words_in_key to 1..MAX_KEY_WORDS and build the word mask
    always_comb
    begin
        if (words_reg == '0)
        begin
            words_eff = WIK_W'(1);
        end
        else if (words_reg > WIK_W'(MAX_KEY_WORDS))
        begin
            words_eff = WIK_W'(MAX_KEY_WORDS);
        end
        else
        begin
            words_eff = words_reg;
        end
        for (int w = 0; w < MAX_KEY_WORDS; w++)
        begin
            word_mask[w] = (WIK_W'(w) < words_eff);
        end
    end

    // Effective range end: negative or beyond the count means the count
    always_comb
    begin
        logic [END_W-1:0] raw_end;
        raw_end = s_tdata[139 +: END_W];
        if (raw_end[END_W-1] || (raw_end[CNT_W-1:0] > count_reg))
        begin
            end_eff = count_reg;
        end
        else
        begin
            end_eff = raw_end[CNT_W-1:0];
        end
    end

    assign begin_in  = s_tdata[130 +: BEGIN_W];
    assign mid_sum   = IDX_W'(lo_reg) + IDX_W'(hi_reg);
    assign lo_plus1  = lo_reg + CNT_W'(1);
    assign out_free  = !m_tvalid_reg || m_tready;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // Sequencer: search, verify, shift rows, write key, present result
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        words_next    = words_reg;
        mv_valid_next = 1'b0;
        mv_addr_next  = mv_addr_reg;
        m_tvalid_next = m_tvalid_reg;
        ptr_next      = ptr_reg;
        mid_next      = mid_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mode_next     = mode_reg;
        key_next      = key_reg;
        ofs_next      = ofs_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        status_next   = status_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        req.rd_en      = 1'b0;
        req.rd_addr    = ptr_reg;
        req.wr_en      = mv_valid_reg;
        req.wr_from_rd = mv_valid_reg;
        req.wr_addr    = mv_addr_reg;

        // Drop a taken result
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        // Take a configuration write
        if (cfg_valid)
        begin
            words_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next   = mode_t'(s_tuser);
                    key_next    = s_tdata[ROW_W-1:0];
                    ofs_next    = s_tdata[128 +: OFS_W];
                    idx_next    = IDX_NONE;
                    found_next  = 1'b0;
                    status_next = 1'b0;
                    unique case (mode_t'(s_tuser))
                        MODE_BOUND:
                        begin
                            hi_next = end_eff;
                            lo_next = (begin_in > end_eff) ? end_eff : begin_in;
                        end
                        MODE_LOOKUP:
                        begin
                            hi_next = count_reg;
                            lo_next = (begin_in > count_reg) ? count_reg : begin_in;
                        end
                        MODE_INSERT:
                        begin
                            hi_next = end_eff;
                            lo_next = '0;
                        end
                        MODE_DELETE:
                        begin
                            hi_next = count_reg;
                            lo_next = '0;
                        end
                        default:
                        begin
                            hi_next = count_reg;
                            lo_next = '0;
                        end
                    endcase
                    state_next = ST_SEARCH;
                end
            end

            ST_SEARCH:
            begin
                if (lo_reg != hi_reg)
                begin
                    // Read the middle row
                    req.rd_en   = 1'b1;
                    req.rd_addr = mid_sum[ADDR_W:1];
                    mid_next    = mid_sum[ADDR_W:1];
                    state_next  = ST_CMP;
                end
                else
                begin
                    // Lower bound settled: dispatch on the operation
                    unique case (mode_reg)
                        MODE_BOUND:
                        begin
                            idx_next   = IDX_W'(lo_reg) + {{(IDX_W-OFS_W){ofs_reg[OFS_W-1]}},
                                                           ofs_reg};
                            state_next = ST_DONE;
                        end
                        MODE_INSERT:
                        begin
                            if (count_reg >= CNT_W'(CAPACITY))
                            begin
                                status_next = 1'b1;
                                state_next  = ST_DONE;
                            end
                            else if (lo_reg < count_reg)
                            begin
                                ptr_next   = ADDR_W'(count_reg - CNT_W'(1));
                                state_next = ST_SHIFT;
                            end
                            else
                            begin
                                state_next = ST_KEYWR;
                            end
                        end
                        MODE_LOOKUP, MODE_DELETE:
                        begin
                            if (lo_reg < count_reg)
                            begin
                                state_next = ST_VREAD;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_CMP:
            begin
                if (cmp.row_lt)
                begin
                    lo_next = CNT_W'(mid_reg) + CNT_W'(1);
                end
                else
                begin
                    hi_next = CNT_W'(mid_reg);
                end
                state_next = ST_SEARCH;
            end

            ST_VREAD:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = lo_reg[ADDR_W-1:0];
                state_next  = ST_VCMP;
            end

            ST_VCMP:
            begin
                state_next = ST_DONE;
                if (cmp.row_eq)
                begin
                    idx_next   = IDX_W'(lo_reg);
                    found_next = 1'b1;
                    if (mode_reg == MODE_DELETE)
                    begin
                        if (lo_plus1 < count_reg)
                        begin
                            ptr_next   = lo_plus1[ADDR_W-1:0];
                            state_next = ST_SHIFT;
                        end
                        else
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end
            end

            ST_SHIFT:
            begin
                // Read one row a cycle; its write follows in the next cycle
                req.rd_en     = 1'b1;
                req.rd_addr   = ptr_reg;
                mv_valid_next = 1'b1;
                if (mode_reg == MODE_INSERT)
                begin
                    mv_addr_next = ptr_reg + ADDR_W'(1);
                    ptr_next     = ptr_reg - ADDR_W'(1);
                    if (CNT_W'(ptr_reg) == lo_reg)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    mv_addr_next = ptr_reg - ADDR_W'(1);
                    ptr_next     = ptr_reg + ADDR_W'(1);
                    if (CNT_W'(ptr_reg) == (count_reg - CNT_W'(1)))
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end

            ST_DRAIN:
            begin
                if (mode_reg == MODE_INSERT)
                begin
                    state_next = ST_KEYWR;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_DONE;
                end
            end

            ST_KEYWR:
            begin
                req.wr_en      = 1'b1;
                req.wr_from_rd = 1'b0;
                req.wr_addr    = lo_reg[ADDR_W-1:0];
                idx_next       = IDX_W'(lo_reg);
                count_next     = count_reg + CNT_W'(1);
                state_next     = ST_DONE;
            end

            ST_DONE:
            begin
                // Hand the result to the output register once it is free
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0000, count_reg, lo_reg, idx_reg};
                    m_tuser_next  = {status_reg, found_reg};
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            words_reg    <= WIK_W'(WIK_RESET);
            mv_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            words_reg    <= words_next;
            mv_valid_reg <= mv_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        mv_addr_reg <= mv_addr_next;
        ptr_reg     <= ptr_next;
        mid_reg     <= mid_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mode_reg    <= mode_next;
        key_reg     <= key_next;
        ofs_reg     <= ofs_next;
        idx_reg     <= idx_next;
        found_reg   <= found_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    smkt_key_store u_key_store
    (
        .clk       (clk),
        .req       (req),
        .key       (key_reg),
        .word_mask (word_mask),
        .cmp       (cmp)
    );

endmodule

// File: hw/rtl/smkt_checker.sv
// ============================================================================
// smkt_checker
// Port-level checks of the sorted key table, bound to its top level.
// ============================================================================
module smkt_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [smkt_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic [1:0]                        m_tuser
);
    import smkt_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Go busy after an operation transfer
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready stayed high after an operation transfer");

    // A found key reports its own position as index
    a_found_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata[9:0] == {1'b0, m_tdata[18:10]}) && !m_tuser[1])
        else $error("found result with inconsistent index");

    // A refused insert only happens on a full table and reports no index
    a_full_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |->
            (m_tdata[9:0] == IDX_NONE) && (m_tdata[27:19] == CNT_W'(CAPACITY)))
        else $error("refused insert on a table that is not full");

    // Never report more entries than the table holds
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[27:19] <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

endmodule

bind sorted_multiword_key_table_unit smkt_checker u_smkt_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
